FILE: rtl/jsesc_pkg.sv
// Shared types, character codes and constants for the JSON string escaper.
package jsesc_pkg;

    // Depth of the job queue between the classifier and the emitter
    localparam int JSESC_QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // "\ufffd", element 0 goes out first
    localparam int         REPL_LEN = 6;
    localparam logic [REPL_LEN-1:0][7:0] REPL_SEQ =
        {8'h64, 8'h66, 8'h66, 8'h66, CH_LC_U, CH_BSLASH};

    // UTF-8 sequence lengths
    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    // One request's worth of output, as the emitter walks it:
    // opening quote, n_repl replacement sequences, body bytes, closing quote.
    typedef struct packed {
        logic            open_quote;
        logic [2:0]      n_repl;
        logic [2:0]      body_len;
        logic [5:0][7:0] body;
        logic            close_quote;
    } job_t;

    // Emitter position
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_REPL,
        PH_BODY,
        PH_CLOSE
    } phase_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        hex_digit = (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (CH_LC_A + {4'd0, n} - 8'd10);
    endfunction

endpackage

FILE: rtl/jsesc_front.sv
// Classifier: tracks open UTF-8 sequences and turns each input request that produces output into a job.
module jsesc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           src_byte,
    input  logic                 first_byte,
    input  logic                 last_byte,
    input  logic                 empty_string,
    output logic                 push_valid,
    input  logic                 push_ready,
    output jsesc_pkg::job_t      push_job
);
    import jsesc_pkg::*;

    logic [7:0] held_bytes_reg [3];
    logic [1:0] held_count_reg, held_count_next;
    logic [2:0] exp_len_reg, exp_len_next;

    logic       held_wr_en;
    logic [1:0] held_wr_idx;
    logic       accept;
    logic       has_out;
    job_t       job;

    logic [5:0][7:0] esc_body;
    logic [2:0]      esc_len;

    assign in_ready = push_ready;
    assign accept   = in_valid & in_ready;

    // ASCII escaping of the current byte
    always_comb begin
        esc_body    = '0;
        esc_len     = 3'd2;
        esc_body[0] = CH_BSLASH;
        case (src_byte)
            CH_QUOTE:  esc_body[1] = CH_QUOTE;
            CH_BSLASH: esc_body[1] = CH_BSLASH;
            CH_LF:     esc_body[1] = CH_LC_N;
            CH_CR:     esc_body[1] = CH_LC_R;
            CH_TAB:    esc_body[1] = CH_LC_T;
            CH_BS:     esc_body[1] = CH_LC_B;
            CH_FF:     esc_body[1] = CH_LC_F;
            default: begin
                if (src_byte < CH_SPACE) begin
                    esc_len     = 3'd6;
                    esc_body[1] = CH_LC_U;
                    esc_body[2] = CH_ZERO;
                    esc_body[3] = CH_ZERO;
                    esc_body[4] = hex_digit(src_byte[7:4]);
                    esc_body[5] = hex_digit(src_byte[3:0]);
                end else begin
                    esc_len     = 3'd1;
                    esc_body[0] = src_byte;
                end
            end
        endcase
    end

    always_comb begin
        logic [1:0] hc;
        logic [2:0] el;
        logic       do_fresh;
        logic [2:0] pre;
        job             = '0;
        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        held_wr_en      = 1'b0;
        held_wr_idx     = 2'd0;
        hc              = held_count_reg;
        el              = exp_len_reg;
        do_fresh        = 1'b0;
        pre             = 3'd0;
        if (empty_string) begin
            job.open_quote  = 1'b1;
            job.close_quote = 1'b1;
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
        end else begin
            if (first_byte) begin
                hc = 2'd0;
                el = 3'd0;
            end
            job.open_quote  = first_byte;
            held_count_next = hc;
            exp_len_next    = el;
            if (hc == 2'd0) begin
                do_fresh = 1'b1;
            end else if (src_byte[7:6] == 2'b10) begin
                if (({1'b0, hc} + 3'd1) >= el) begin
                    // sequence complete: copy it out
                    job.body[0]     = held_bytes_reg[0];
                    job.body[1]     = (hc > 2'd1) ? held_bytes_reg[1] : src_byte;
                    job.body[2]     = (hc > 2'd2) ? held_bytes_reg[2] : src_byte;
                    job.body[3]     = src_byte;
                    job.body_len    = {1'b0, hc} + 3'd1;
                    held_count_next = 2'd0;
                    exp_len_next    = 3'd0;
                end else if (hc < 2'd3) begin
                    held_wr_en      = 1'b1;
                    held_wr_idx     = hc;
                    held_count_next = hc + 2'd1;
                end else begin
                    pre             = {1'b0, hc};
                    do_fresh        = 1'b1;
                    held_count_next = 2'd0;
                    exp_len_next    = 3'd0;
                end
            end else begin
                // non-continuation: replace what is held, then retry the byte
                pre             = {1'b0, hc};
                do_fresh        = 1'b1;
                held_count_next = 2'd0;
                exp_len_next    = 3'd0;
            end

            if (do_fresh) begin
                if (!src_byte[7]) begin
                    job.body     = esc_body;
                    job.body_len = esc_len;
                end else if (src_byte[7:5] == 3'b110) begin
                    held_wr_en      = 1'b1;
                    held_count_next = 2'd1;
                    exp_len_next    = SEQ_LEN_2;
                end else if (src_byte[7:4] == 4'b1110) begin
                    held_wr_en      = 1'b1;
                    held_count_next = 2'd1;
                    exp_len_next    = SEQ_LEN_3;
                end else if (src_byte[7:3] == 5'b11110) begin
                    held_wr_en      = 1'b1;
                    held_count_next = 2'd1;
                    exp_len_next    = SEQ_LEN_4;
                end else begin
                    job.body     = REPL_SEQ;
                    job.body_len = 3'(REPL_LEN);
                end
            end

            if (last_byte) begin
                // cut-off sequence: one replacement per held byte
                job.n_repl      = pre + {1'b0, held_count_next};
                job.close_quote = 1'b1;
                held_count_next = 2'd0;
                exp_len_next    = 3'd0;
            end else begin
                job.n_repl = pre;
            end
        end
    end

    assign has_out    = job.open_quote | job.close_quote |
                        (job.n_repl != 3'd0) | (job.body_len != 3'd0);
    assign push_valid = in_valid & has_out;
    assign push_job   = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
            exp_len_reg    <= 3'd0;
        end else if (accept) begin
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && held_wr_en) begin
            held_bytes_reg[held_wr_idx] <= src_byte;
        end
    end

endmodule

FILE: rtl/jsesc_queue.sv
// Small job queue between the classifier and the emitter.
module jsesc_queue #(
    parameter int DEPTH = jsesc_pkg::JSESC_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  jsesc_pkg::job_t  push_job,
    output logic             pop_valid,
    input  logic             pop_ready,
    output jsesc_pkg::job_t  pop_job
);
    import jsesc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/jsesc_back.sv
// Emitter: walks the head job one output byte per cycle into the output register while the output is not stalled.
module jsesc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_pop,
    input  jsesc_pkg::job_t  job,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import jsesc_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] rep_reg, rep_next;
    logic [2:0] idx_reg, idx_next;

    phase_t     cur_phase;
    logic [1:0] cur_rep;
    logic [2:0] cur_idx;
    logic       done;
    logic [7:0] cur_byte;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       step;

    assign step    = (!m_tvalid_reg || m_tready) && job_valid;
    assign job_pop = step && done;

    // Position of the byte loaded into the output register this cycle
    always_comb begin
        if (phase_reg == PH_IDLE) begin
            cur_rep = 2'd0;
            cur_idx = 3'd0;
            if (job.open_quote) begin
                cur_phase = PH_OPEN;
            end else if (job.n_repl != 3'd0) begin
                cur_phase = PH_REPL;
            end else if (job.body_len != 3'd0) begin
                cur_phase = PH_BODY;
            end else begin
                cur_phase = PH_CLOSE;
            end
        end else begin
            cur_phase = phase_reg;
            cur_rep   = rep_reg;
            cur_idx   = idx_reg;
        end
    end

    // Next position
    always_comb begin
        phase_next = cur_phase;
        rep_next   = cur_rep;
        idx_next   = cur_idx;
        done       = 1'b0;
        case (cur_phase)
            PH_OPEN: begin
                rep_next = 2'd0;
                idx_next = 3'd0;
                if (job.n_repl != 3'd0) begin
                    phase_next = PH_REPL;
                end else if (job.body_len != 3'd0) begin
                    phase_next = PH_BODY;
                end else if (job.close_quote) begin
                    phase_next = PH_CLOSE;
                end else begin
                    done = 1'b1;
                end
            end
            PH_REPL: begin
                if (cur_idx != 3'(REPL_LEN - 1)) begin
                    idx_next = cur_idx + 3'd1;
                end else if (({1'b0, cur_rep} + 3'd1) < job.n_repl) begin
                    rep_next = cur_rep + 2'd1;
                    idx_next = 3'd0;
                end else if (job.body_len != 3'd0) begin
                    phase_next = PH_BODY;
                    idx_next   = 3'd0;
                end else if (job.close_quote) begin
                    phase_next = PH_CLOSE;
                end else begin
                    done = 1'b1;
                end
            end
            PH_BODY: begin
                if ((cur_idx + 3'd1) < job.body_len) begin
                    idx_next = cur_idx + 3'd1;
                end else if (job.close_quote) begin
                    phase_next = PH_CLOSE;
                end else begin
                    done = 1'b1;
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase
        if (done) begin
            phase_next = PH_IDLE;
        end
    end

    // Byte for the current position
    always_comb begin
        case (cur_phase)
            PH_REPL: cur_byte = REPL_SEQ[cur_idx];
            PH_BODY: cur_byte = job.body[cur_idx];
            default: cur_byte = CH_QUOTE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            rep_reg      <= 2'd0;
            idx_reg      <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (step) begin
                phase_reg    <= phase_next;
                rep_reg      <= rep_next;
                idx_reg      <= idx_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/json_string_escaper_utf8_sanitizer_core.sv
// Top level of the JSON string escaper with UTF-8 sanitizing.
//
// Takes one raw string byte per request on the s_ side and sends the quoted,
// escaped JSON text on the m_ side, one byte per request. The first byte of
// a string brings the opening quote, the last byte the closing quote; an
// empty-string request gives two quotes. ASCII gets the usual JSON escapes
// (\" \\ \n \r \t \b \f, \u00xx for other control codes). A UTF-8 lead byte
// and its continuation bytes are held until the sequence is complete and
// then copied out; a bad lead byte, a broken sequence or one cut off by the
// end of the string becomes \ufffd for each held byte. m_tlast marks the
// last output byte caused by each input request; a request whose byte is only
// held and that brings no quote produces no output at all. Overlong forms and
// surrogates pass unchecked.
// Rate: the classifier takes one input request per cycle while the queue has
// room. The emitter sends one output byte per cycle while a job is queued and
// m_tready is high; a request produces 1 output byte for a plain byte, 2 for
// a short escape, 6 for \u00xx or \ufffd and up to 25 with quotes and
// replacements. A queue of QUEUE_DEPTH jobs sits between the two; s_tready
// drops only while that queue is full.
module json_string_escaper_utf8_sanitizer_core #(
    parameter int QUEUE_DEPTH = jsesc_pkg::JSESC_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input requests
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] src_byte
    input  logic [1:0] s_tuser,   // [0] first_byte, [1] empty_string
    input  logic       s_tlast,   // last_byte
    // output requests
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_end
);
    import jsesc_pkg::*;

    // classifier -> queue
    logic push_valid, push_ready;
    job_t push_job;
    // queue -> emitter
    logic pop_valid, pop_ready;
    job_t pop_job;

    jsesc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .src_byte     (s_tdata),
        .first_byte   (s_tuser[0]),
        .last_byte    (s_tlast),
        .empty_string (s_tuser[1]),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_job     (push_job)
    );

    jsesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // emitter pops the head job as its last byte is loaded
    jsesc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_pop   (pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
